// ----- rtl/vrss_pkg.sv -----
// Shared constants, codes and types for the per-voxel root-sum-of-squares block.
package vrss_pkg;

    localparam int VOXELS      = 65536;
    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_W - 1;
    localparam int ACC_W       = 40;
    localparam int ROOT_W      = ACC_W / 2;
    localparam int ROOT_STEPS  = ACC_W / 2;
    localparam int STEP_W      = $clog2(ROOT_STEPS);

    localparam logic [ACC_W-1:0] ACC_FULL = '1;

    localparam logic [1:0] MODE_ACC   = 2'd0;
    localparam logic [1:0] MODE_EMIT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_ROOT,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

// ----- rtl/vrss_sqrt.sv -----
// Iterative floor square root, one result bit per cycle.
module vrss_sqrt
    import vrss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_radicand,
    output t_sqrt_stat        o_stat,
    output logic [ROOT_W-1:0] o_root
);

    logic [ACC_W-1:0]  r_rad;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] rem_diff;
    logic              ge;

    // The partial remainder never reaches 2^(ROOT_W+1), so its top bits can be dropped.
    always_comb begin
        rem_sh   = {r_rem, r_rad[ACC_W-1:ACC_W-2]};
        trial    = {1'b0, r_root, 2'b01};
        ge       = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= STEP_W'(ROOT_STEPS - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[ACC_W-3:0], 2'b00};
            r_rem  <= ge ? rem_diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

// ----- rtl/voxel_root_sum_squares.sv -----
// Per-voxel sum-of-squares store with a saturating update and root readout.
// Accumulate reads the memory, then adds and writes back; clear writes in S_IDLE.
// Emit reads the memory, runs the 20 steps of the bit-serial root unit, then loads the
// output register; it waits in S_PUSH while that register holds a stalled result.
// A result waiting in the output register does not hold off the next request.
// After reset the memory is zeroed one entry a cycle, and no request is taken until all
// 65536 entries are clear.
module voxel_root_sum_squares
    import vrss_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_mode,
    input  logic [15:0]                i_voxel_index,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [15:0]                o_voxel_out,
    output logic [ROOT_W-1:0]          o_root,
    output logic                       o_saturated
);

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_idx;
    logic              r_idx_ok;
    logic [SQ_W-1:0]   r_sq;
    logic [ACC_W:0]    r_rd_data;
    logic              r_sat;

    logic              r_out_valid;
    logic [15:0]       r_out_voxel;
    logic [ROOT_W-1:0] r_out_root;
    logic              r_out_sat;

    // Each entry holds the saturation mark above the accumulator.
    logic [ACC_W:0]    r_mem [STORE_DEPTH];

    logic              in_accept;
    logic              in_idx_ok;
    logic              out_free;
    logic              out_load;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ACC_W:0]    wr_data;
    logic              sqrt_start;
    logic [ACC_W-1:0]  radicand;
    t_sqrt_stat        sqrt_stat;
    logic [ROOT_W-1:0] sqrt_root;

    logic [MAG_W-1:0]   samp_ext;
    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] sq_full;
    logic [ACC_W:0]     sum;
    logic [ACC_W:0]     acc_next;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign in_idx_ok = (32'(i_voxel_index) < VOXELS);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        samp_ext = {i_sample[SAMPLE_W-1], i_sample};
        mag      = i_sample[SAMPLE_W-1] ? (~samp_ext + 1'b1) : samp_ext;
        sq_full  = mag * mag;
    end

    // The sum cannot pass twice full scale, so the carry out alone flags saturation.
    always_comb begin
        sum = {1'b0, r_rd_data[ACC_W-1:0]} + (ACC_W+1)'(r_sq);
        if (sum[ACC_W]) begin
            acc_next = {1'b1, ACC_FULL};
        end else begin
            acc_next = {r_rd_data[ACC_W], sum[ACC_W-1:0]};
        end
    end

    assign radicand = r_idx_ok ? r_rd_data[ACC_W-1:0] : '0;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = '0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_mode) inside
                        MODE_ACC, MODE_EMIT: begin
                            n_state = S_CALC;
                        end
                        MODE_CLEAR: begin
                            wr_en   = in_idx_ok;
                            wr_addr = i_voxel_index;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (r_mode == MODE_ACC) begin
                    wr_en   = r_idx_ok;
                    wr_data = acc_next;
                    n_state = S_IDLE;
                end else begin
                    sqrt_start = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                if (sqrt_stat.done) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[i_voxel_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode   <= i_mode;
            r_idx    <= i_voxel_index;
            r_idx_ok <= in_idx_ok;
            r_sq     <= sq_full[SQ_W-1:0];
        end
        if (r_state == S_CALC) begin
            r_sat <= r_idx_ok && r_rd_data[ACC_W];
        end
    end

    vrss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_stat     (sqrt_stat),
        .o_root     (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_voxel <= r_idx;
            r_out_root  <= sqrt_root;
            r_out_sat   <= r_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_voxel_out = r_out_voxel;
    assign o_root      = r_out_root;
    assign o_saturated = r_out_sat;

    // A set mark always comes with an accumulator held at full scale.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && wr_data[ACC_W]) |-> (wr_data[ACC_W-1:0] == ACC_FULL))
        else $error("saturation mark written with accumulator below full scale");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("root unit started while busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_stall))
        else $error("output register overwritten while a result waits");

    // The update step always follows the memory read of its own request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> $past(in_accept))
        else $error("update step without a preceding memory read");

endmodule

// ----- tb/tb_voxel_root_sum_squares.sv -----
// Self-checking testbench for the per-voxel root-sum-of-squares block.
`timescale 1ns / 1ps

module tb_voxel_root_sum_squares;
    import vrss_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOT_VOXELS = 8;
    localparam int RANDOM_REQUESTS = 650;
    localparam int HEAVY_RUN = 240;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]          mode;
        logic [15:0]         voxel;
        logic [SAMPLE_W-1:0] sample;
    } t_voxel_req;

    typedef struct packed {
        logic [15:0]       voxel;
        logic [ROOT_W-1:0] root;
        logic              saturated;
    } t_root_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SCATTER,
        STALL_RUNS
    } t_stall_style;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_mode = MODE_ACC;
    logic [15:0]                i_voxel_index = '0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [15:0]                o_voxel_out;
    logic [ROOT_W-1:0]          o_root;
    logic                       o_saturated;

    t_voxel_req   voxel_requests[$];
    t_root_result expected_roots[$];

    // Predicted contents of the block's per-voxel store.
    bit [ACC_W-1:0] sum_store [VOXELS];
    bit             mark_store [VOXELS];

    logic [15:0] hot_voxels [HOT_VOXELS];
    int          request_count = 0;
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    t_stall_style stall_style = STALL_NONE;
    int          stall_age = 0;
    int          stall_run = 0;

    voxel_root_sum_squares dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_voxel_index (i_voxel_index),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_voxel_out   (o_voxel_out),
        .o_root        (o_root),
        .o_saturated   (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [ROOT_W-1:0] floor_root40(logic [ACC_W-1:0] value);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        longint unsigned   square;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root;
            trial[b] = 1'b1;
            square = longint'(trial) * longint'(trial);
            if (square <= longint'(value))
                root = trial;
        end
        return root;
    endfunction

    // Updates the predicted store for one accepted request and, for an emit, queues the root it yields.
    function automatic void apply_voxel_request(logic [1:0] mode, logic [15:0] voxel,
                                                logic signed [SAMPLE_W-1:0] sample);
        longint unsigned square;
        longint unsigned total;
        t_root_result    res;
        bit              in_range;
        in_range = int'(voxel) < VOXELS;
        case (mode)
            MODE_ACC: begin
                if (in_range) begin
                    square = longint'(sample) * longint'(sample);
                    total = longint'(sum_store[voxel]) + square;
                    if (total > longint'(ACC_FULL)) begin
                        total = longint'(ACC_FULL);
                        mark_store[voxel] = 1'b1;
                    end
                    sum_store[voxel] = total[ACC_W-1:0];
                end
            end
            MODE_EMIT: begin
                res.voxel = voxel;
                res.root = in_range ? floor_root40(sum_store[voxel]) : '0;
                res.saturated = in_range ? mark_store[voxel] : 1'b0;
                expected_roots.push_back(res);
            end
            MODE_CLEAR: begin
                if (in_range) begin
                    sum_store[voxel] = '0;
                    mark_store[voxel] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_request(logic [1:0] mode, logic [15:0] voxel,
                                          logic [SAMPLE_W-1:0] sample);
        t_voxel_req req;
        req.mode = mode;
        req.voxel = voxel;
        req.sample = sample;
        voxel_requests.push_back(req);
        if (mode != MODE_UNUSED)
            request_count++;
    endfunction

    function automatic logic [15:0] pick_voxel();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom_range(0, 65535));
        return hot_voxels[$urandom_range(0, HOT_VOXELS - 1)];
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly accumulate runs closed by an emit on the same voxel, with stray requests between.
    task automatic add_random_traffic(input int target);
        logic [15:0] voxel;
        while (request_count < target) begin
            if ($urandom_range(0, 9) < 7) begin
                voxel = pick_voxel();
                repeat ($urandom_range(1, 6))
                    queue_request(MODE_ACC, voxel, random_sample());
                if ($urandom_range(0, 7) == 0) begin
                    queue_request(MODE_CLEAR, voxel, 16'($urandom));
                    queue_request(MODE_ACC, voxel, random_sample());
                end
                queue_request(MODE_EMIT, voxel, 16'($urandom));
            end else begin
                // Any mode, the unused one included.
                queue_request(2'($urandom_range(0, 3)), pick_voxel(), 16'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_voxel_req next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid)
                apply_voxel_request(i_mode, i_voxel_index, i_sample);
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (voxel_requests.size() != 0) begin
                next_req = voxel_requests.pop_front();
                i_mode <= next_req.mode;
                i_voxel_index <= next_req.voxel;
                i_sample <= next_req.sample;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 2));
            stall_age <= $urandom_range(100, 400);
        end else begin
            stall_age <= stall_age - 1;
        end
        case (stall_style)
            STALL_NONE: i_stall <= 1'b0;
            STALL_SCATTER: i_stall <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_run == 0) begin
                    i_stall <= ~i_stall;
                    stall_run <= $urandom_range(1, 25);
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : check_roots
        t_root_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_roots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected root: voxel %0d root %0d saturated %0b",
                             $realtime, o_voxel_out, o_root, o_saturated);
            end else begin
                want = expected_roots.pop_front();
                if (o_voxel_out !== want.voxel || o_root !== want.root ||
                    o_saturated !== want.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 $realtime, want.voxel, want.root, want.saturated,
                                 o_voxel_out, o_root, o_saturated);
                end
            end
        end
    end

    initial begin
        logic [15:0] heavy_voxel;
        int          mag;
        hot_voxels[0] = 16'h0000;
        hot_voxels[1] = 16'hFFFF;
        for (int i = 2; i < HOT_VOXELS; i++)
            hot_voxels[i] = 16'($urandom);

        // Extremes of index and sample, ignored samples, the unused mode and clear.
        queue_request(MODE_EMIT, 16'h0000, 16'h1234);
        queue_request(MODE_ACC, 16'h0000, 16'h8000);
        queue_request(MODE_EMIT, 16'h0000, 16'h0000);
        queue_request(MODE_ACC, 16'hFFFF, 16'h7FFF);
        queue_request(MODE_ACC, 16'hFFFF, 16'hFFFF);
        queue_request(MODE_EMIT, 16'hFFFF, 16'hFFFF);
        queue_request(MODE_ACC, 16'h0001, 16'h0000);
        queue_request(MODE_EMIT, 16'h0001, 16'h8000);
        queue_request(MODE_ACC, 16'h0002, 16'h0001);
        queue_request(MODE_EMIT, 16'h0002, 16'h7FFF);
        queue_request(MODE_UNUSED, 16'h0000, 16'h7FFF);
        queue_request(MODE_UNUSED, 16'hFFFF, 16'h8000);
        queue_request(MODE_EMIT, 16'h0000, 16'h5555);
        queue_request(MODE_CLEAR, 16'h0000, 16'hFFFF);
        queue_request(MODE_EMIT, 16'h0000, 16'hAAAA);
        // Consecutive updates of one voxel exercise the read-modify-write of its entry.
        queue_request(MODE_ACC, 16'h0005, 16'h0100);
        queue_request(MODE_ACC, 16'h0005, 16'hFF00);
        queue_request(MODE_ACC, 16'h0005, 16'h0180);
        queue_request(MODE_EMIT, 16'h0005, 16'h0000);
        queue_request(MODE_CLEAR, 16'hFFFF, 16'h0000);
        queue_request(MODE_EMIT, 16'hFFFF, 16'h0000);
        queue_request(MODE_ACC, 16'hAAAA, 16'h5555);
        queue_request(MODE_EMIT, 16'hAAAA, 16'h0000);

        add_random_traffic(RANDOM_REQUESTS / 2);

        // Push one hot voxel high into its range with near full-scale samples so that the
        // upper root bits are exercised, then clear it.
        heavy_voxel = hot_voxels[$urandom_range(2, HOT_VOXELS - 1)];
        for (int i = 0; i < HEAVY_RUN; i++) begin
            mag = $urandom_range(32256, 32768);
            if ($urandom_range(0, 1) == 0)
                queue_request(MODE_ACC, heavy_voxel, 16'(-mag));
            else
                queue_request(MODE_ACC, heavy_voxel, 16'((mag > 32767) ? 32767 : mag));
            if (i % 60 == 59)
                queue_request(MODE_EMIT, heavy_voxel, 16'($urandom));
        end
        queue_request(MODE_EMIT, heavy_voxel, 16'($urandom));
        queue_request(MODE_ACC, heavy_voxel, 16'h0000);
        queue_request(MODE_EMIT, heavy_voxel, 16'($urandom));
        queue_request(MODE_CLEAR, heavy_voxel, 16'($urandom));
        queue_request(MODE_EMIT, heavy_voxel, 16'($urandom));
        queue_request(MODE_ACC, heavy_voxel, random_sample());
        queue_request(MODE_EMIT, heavy_voxel, 16'($urandom));

        add_random_traffic(RANDOM_REQUESTS);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (voxel_requests.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_roots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
